>>> hw/rtl/smpr_pkg.sv
// Shared types and constants for the Simpson rule integrator.
// Used by smpr_div, smpr_dp, smpr_ctrl and simpson_rule_integrator_top.
package smpr_pkg;

    localparam int GUARD_BITS = 16;
    localparam int BND_W      = 32;
    localparam int CNT_W      = 11;
    localparam int X_W        = BND_W + GUARD_BITS;
    localparam int HM_W       = 48;
    localparam int DIV_W      = 64;
    localparam int DVS_W      = 12;
    localparam int DCNT_W     = 7;
    localparam int IDX_W      = 12;
    localparam int MCH_W      = 16;
    localparam int MUL_STEPS  = 3;
    localparam int MCNT_W     = 2;
    localparam int PROD_W     = HM_W + DIV_W;

    // divide by three: q = (x * THIRD_MUL) >> THIRD_W, exact for x < 2^THIRD_W
    localparam int          THIRD_W   = BND_W + 1;
    localparam logic [31:0] THIRD_MUL = 32'hAAAA_AAAB;

    localparam logic [1:0] W_ONE  = 2'd0;
    localparam logic [1:0] W_TWO  = 2'd1;
    localparam logic [1:0] W_FOUR = 2'd2;

    typedef struct packed {
        logic signed [BND_W-1:0] lower_bound;
        logic signed [BND_W-1:0] upper_bound;
        logic [CNT_W-1:0]        pair_count;
    } t_in;

    typedef struct packed {
        logic signed [BND_W-1:0] integral_value;
        logic                    overflow;
        logic                    bad_count;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP_GO,
        S_STEP_WAIT,
        S_WALK,
        S_DRAIN,
        S_MUL_LD,
        S_MUL,
        S_THIRD,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_go;
        logic div_third;
        logic take_step;
        logic walk;
        logic mul_load;
        logic mul_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic count_bad;
        logic div_done;
        logic last_pt;
        logic pipe_busy;
        logic mul_last;
    } t_sts;

endpackage

>>> hw/rtl/smpr_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 12-bit divisor.
// Depends on smpr_pkg.
module smpr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [smpr_pkg::DIV_W-1:0]   i_dividend,
    input  logic [smpr_pkg::DVS_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [smpr_pkg::DIV_W-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [smpr_pkg::DCNT_W-1:0]   r_cnt;
    logic [smpr_pkg::DIV_W-1:0]    r_quo;
    logic [smpr_pkg::DVS_W-1:0]    r_rem;
    logic [smpr_pkg::DVS_W-1:0]    r_dvs;
    logic [smpr_pkg::DVS_W:0]      rem_sh;
    logic                          q_bit;
    logic [smpr_pkg::DVS_W-1:0]    n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[smpr_pkg::DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        if (q_bit) begin
            n_rem = smpr_pkg::DVS_W'(rem_sh - {1'b0, r_dvs});
        end else begin
            n_rem = rem_sh[smpr_pkg::DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= smpr_pkg::DCNT_W'(smpr_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == smpr_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[smpr_pkg::DIV_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hw/rtl/smpr_dp.sv
// Datapath: step division, per-point polynomial pipeline, accumulator,
// final scaling and saturation. Depends on smpr_pkg and smpr_div.
module smpr_dp #(
    parameter int MAX_PAIRS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smpr_pkg::t_in    i_item,
    input  smpr_pkg::t_cmd   i_cmd,
    output smpr_pkg::t_sts   o_sts,
    output smpr_pkg::t_out   o_result
);

    localparam int SHIFT = FRAC_BITS + smpr_pkg::GUARD_BITS;

    logic signed [smpr_pkg::BND_W-1:0]  r_a;
    logic signed [smpr_pkg::BND_W-1:0]  r_b;
    logic [smpr_pkg::CNT_W-1:0]         r_n;
    logic                               r_dneg;
    logic [smpr_pkg::HM_W-1:0]          r_hm;
    logic signed [smpr_pkg::HM_W:0]     r_step;
    logic signed [smpr_pkg::X_W-1:0]    r_x;
    logic [smpr_pkg::IDX_W-1:0]         r_idx;

    logic                               r1_v;
    logic signed [smpr_pkg::BND_W-1:0]  r1_xq;
    logic [smpr_pkg::BND_W-1:0]         r1_xm;
    logic [1:0]                         r1_w;
    logic                               r2_v;
    logic signed [smpr_pkg::BND_W-1:0]  r2_xq;
    logic [2*smpr_pkg::BND_W-1:0]       r2_sq;
    logic [1:0]                         r2_w;
    logic                               r3_v;
    logic [63:0]                        r3_f;
    logic [1:0]                         r3_w;
    logic [63:0]                        r_sum;

    logic [63:0]                        r_sm;
    logic                               r_neg;
    logic [smpr_pkg::HM_W-1:0]          r_hsh;
    logic [smpr_pkg::PROD_W-1:0]        r_prod;
    logic [smpr_pkg::MCNT_W-1:0]        r_mcnt;
    logic                               r_ovf;
    logic [smpr_pkg::BND_W-1:0]         r_q3;
    smpr_pkg::t_out                     r_res;

    logic signed [smpr_pkg::BND_W:0]    d;
    logic [smpr_pkg::BND_W:0]           dmag;
    logic [smpr_pkg::DVS_W-1:0]         segs;
    logic [smpr_pkg::DIV_W-1:0]         div_dividend;
    logic [smpr_pkg::DVS_W-1:0]         div_divisor;
    logic                               div_done;
    logic [smpr_pkg::DIV_W-1:0]         quo;
    logic signed [smpr_pkg::BND_W-1:0]  xq;
    logic [smpr_pkg::BND_W-1:0]         xm;
    logic [1:0]                         w_code;
    logic [63:0]                        x2;
    logic [63:0]                        f_val;
    logic [smpr_pkg::DIV_W+smpr_pkg::MCH_W-1:0] mp;
    logic                               qhi;
    logic [smpr_pkg::DIV_W-1:0]         qlo;
    logic [63:0]                        thresh;
    logic                               ovf;
    logic [smpr_pkg::THIRD_W+smpr_pkg::BND_W-1:0] t3_prod;

    assign d    = $signed({r_b[smpr_pkg::BND_W-1], r_b}) - $signed({r_a[smpr_pkg::BND_W-1], r_a});
    assign dmag = d[smpr_pkg::BND_W] ? (smpr_pkg::BND_W+1)'(-d) : d;
    assign segs = {1'b0, r_n} << 1;

    assign div_dividend = {{(smpr_pkg::DIV_W-smpr_pkg::BND_W-1-smpr_pkg::GUARD_BITS){1'b0}},
                           dmag, {smpr_pkg::GUARD_BITS{1'b0}}};
    assign div_divisor  = segs;

    smpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        xq = r_x[smpr_pkg::X_W-1:smpr_pkg::GUARD_BITS];
        xm = xq[smpr_pkg::BND_W-1] ? smpr_pkg::BND_W'(-xq) : xq;
        if (r_idx == '0 || r_idx == segs) begin
            w_code = smpr_pkg::W_ONE;
        end else if (r_idx[0]) begin
            w_code = smpr_pkg::W_FOUR;
        end else begin
            w_code = smpr_pkg::W_TWO;
        end
        x2    = r2_sq >> FRAC_BITS;
        f_val = (x2 << 1) + x2 - {{32{r2_xq[smpr_pkg::BND_W-1]}}, r2_xq}
                - (64'd1 << FRAC_BITS);
        mp    = (smpr_pkg::DIV_W+smpr_pkg::MCH_W)'(r_sm)
                * (smpr_pkg::DIV_W+smpr_pkg::MCH_W)'(r_hsh[smpr_pkg::HM_W-1 -: smpr_pkg::MCH_W]);
    end

    // quotient by three exceeds the limit exactly when qlo >= 3 * (limit + 1)
    always_comb begin
        qhi     = |r_prod[smpr_pkg::PROD_W-1:SHIFT+smpr_pkg::DIV_W];
        qlo     = r_prod[SHIFT +: smpr_pkg::DIV_W];
        thresh  = r_neg ? 64'h0000_0001_8000_0003 : 64'h0000_0001_8000_0000;
        ovf     = qhi || (qlo >= thresh);
        t3_prod = (smpr_pkg::THIRD_W+smpr_pkg::BND_W)'(qlo[smpr_pkg::THIRD_W-1:0])
                  * (smpr_pkg::THIRD_W+smpr_pkg::BND_W)'(smpr_pkg::THIRD_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_cmd.walk;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_item.lower_bound;
            r_b   <= i_item.upper_bound;
            r_n   <= i_item.pair_count;
            r_res <= '{integral_value: '0, overflow: 1'b0, bad_count: 1'b1};
        end
        if (i_cmd.take_step) begin
            r_hm   <= quo[smpr_pkg::HM_W-1:0];
            r_dneg <= d[smpr_pkg::BND_W];
            r_step <= d[smpr_pkg::BND_W] ? -$signed({1'b0, quo[smpr_pkg::HM_W-1:0]})
                                         : $signed({1'b0, quo[smpr_pkg::HM_W-1:0]});
            r_x    <= {r_a, {smpr_pkg::GUARD_BITS{1'b0}}};
            r_idx  <= '0;
            r_sum  <= '0;
        end
        if (i_cmd.walk) begin
            r1_xq <= xq;
            r1_xm <= xm;
            r1_w  <= w_code;
            r_x   <= smpr_pkg::X_W'($signed({r_x[smpr_pkg::X_W-1], r_x}) + r_step);
            r_idx <= r_idx + 1'b1;
        end
        r2_xq <= r1_xq;
        r2_sq <= 64'(r1_xm) * 64'(r1_xm);
        r2_w  <= r1_w;
        r3_f  <= f_val;
        r3_w  <= r2_w;
        if (r3_v) begin
            r_sum <= r_sum + (r3_f << r3_w);
        end
        if (i_cmd.mul_load) begin
            r_sm   <= r_sum[63] ? 64'(-r_sum) : r_sum;
            r_neg  <= r_sum[63] ^ r_dneg;
            r_hsh  <= r_hm;
            r_prod <= '0;
            r_mcnt <= '0;
        end
        if (i_cmd.mul_step) begin
            r_prod <= (r_prod << smpr_pkg::MCH_W) + smpr_pkg::PROD_W'(mp);
            r_hsh  <= r_hsh << smpr_pkg::MCH_W;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.div_third) begin
            r_ovf <= ovf;
            r_q3  <= t3_prod[smpr_pkg::THIRD_W +: smpr_pkg::BND_W];
        end
        if (i_cmd.finish) begin
            r_res.bad_count <= 1'b0;
            r_res.overflow  <= r_ovf;
            if (r_ovf) begin
                r_res.integral_value <= r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_res.integral_value <= r_neg ? $signed(-r_q3) : $signed(r_q3);
            end
        end
    end

    always_comb begin
        o_sts.count_bad = (i_item.pair_count == '0)
                          || (32'(i_item.pair_count) > 32'(MAX_PAIRS));
        o_sts.div_done  = div_done;
        o_sts.last_pt   = (r_idx == segs);
        o_sts.pipe_busy = r1_v | r2_v | r3_v;
        o_sts.mul_last  = (r_mcnt == smpr_pkg::MCNT_W'(smpr_pkg::MUL_STEPS - 1));
    end

    assign o_result = r_res;

endmodule

>>> hw/rtl/smpr_ctrl.sv
// Controller state machine: sequences step division, point walk,
// final multiply and divide by three. Depends on smpr_pkg.
module smpr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  smpr_pkg::t_sts   i_sts,
    output smpr_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_valid
);

    smpr_pkg::t_state r_state;
    smpr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smpr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            smpr_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = i_sts.count_bad ? smpr_pkg::S_DONE : smpr_pkg::S_STEP_GO;
                end
            end
            smpr_pkg::S_STEP_GO:   n_state = smpr_pkg::S_STEP_WAIT;
            smpr_pkg::S_STEP_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = smpr_pkg::S_WALK;
                end
            end
            smpr_pkg::S_WALK: begin
                if (i_sts.last_pt) begin
                    n_state = smpr_pkg::S_DRAIN;
                end
            end
            smpr_pkg::S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = smpr_pkg::S_MUL_LD;
                end
            end
            smpr_pkg::S_MUL_LD:    n_state = smpr_pkg::S_MUL;
            smpr_pkg::S_MUL: begin
                if (i_sts.mul_last) begin
                    n_state = smpr_pkg::S_THIRD;
                end
            end
            smpr_pkg::S_THIRD:     n_state = smpr_pkg::S_FINISH;
            smpr_pkg::S_FINISH:    n_state = smpr_pkg::S_DONE;
            smpr_pkg::S_DONE:      n_state = smpr_pkg::S_IDLE;
            default:               n_state = smpr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            smpr_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            smpr_pkg::S_STEP_GO:   o_cmd.div_go = 1'b1;
            smpr_pkg::S_STEP_WAIT: o_cmd.take_step = i_sts.div_done;
            smpr_pkg::S_WALK:      o_cmd.walk = 1'b1;
            smpr_pkg::S_DRAIN:     o_cmd = '0;
            smpr_pkg::S_MUL_LD:    o_cmd.mul_load = 1'b1;
            smpr_pkg::S_MUL:       o_cmd.mul_step = 1'b1;
            smpr_pkg::S_THIRD:     o_cmd.div_third = 1'b1;
            smpr_pkg::S_FINISH:    o_cmd.finish = 1'b1;
            smpr_pkg::S_DONE:      o_valid = 1'b1;
            default:               o_busy = 1'b0;
        endcase
    end

endmodule

>>> hw/rtl/simpson_rule_integrator_top.sv
// Simpson rule integrator of 3x^2 - x - 1 over [lower_bound, upper_bound].
// Sequence from accept to result for n pairs: step divide, 2n+1 points at one per
// cycle, pipeline drain, multiply, divide by three and saturation, output strobe;
// a rejected count goes straight to the output strobe.
// Throughput: one item at a time; the next item is accepted once busy falls.
// Reset: synchronous, active low, returns to idle; the receiver cannot stall.
module simpson_rule_integrator_top #(
    parameter int MAX_PAIRS = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  smpr_pkg::t_in    i_item,
    output logic             o_valid,
    output smpr_pkg::t_out   o_result
);

    smpr_pkg::t_cmd cmd;
    smpr_pkg::t_sts sts;

    smpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    smpr_dp #(
        .MAX_PAIRS (MAX_PAIRS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.bad_count |-> o_result.integral_value == '0 && !o_result.overflow)
        else $error("rejected count with nonzero result");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.overflow |->
            o_result.integral_value == 32'sh7FFF_FFFF
            || o_result.integral_value == 32'sh8000_0000)
        else $error("overflow without saturated value");
`endif

endmodule
